/* rtl/srcs_pkg.sv */
// Shared constants and types for the SPI register command slave.
`timescale 1ns / 1ps
package srcs_pkg;

	localparam int STORE_ADDR_BITS_DEF = 14;

	localparam logic [3:0] CMD_RD = 4'hA;
	localparam logic [3:0] CMD_WR = 4'hB;

	localparam logic [7:0] FILLER = 8'h5A;

	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_RD  = 2'd1;
	localparam logic [1:0] PH_WR  = 2'd2;

	localparam logic [1:0] HDR_LAST = 2'd3;

	// Store access request from the sequencer; addr is the full byte address
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} store_req_t;

endpackage

/* rtl/srcs_rx_if.sv */
// Request channel carrying one received SPI byte per slot.
`timescale 1ns / 1ps
interface srcs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/srcs_tx_if.sv */
// Result channel carrying the byte shifted out per slot and its slot kind.
`timescale 1ns / 1ps
interface srcs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic [1:0] phase;
	logic       transfer_done;

	modport source (output valid, output tx_byte, output phase, output transfer_done,
		input ready);
	modport sink (input valid, input tx_byte, input phase, input transfer_done,
		output ready);
endinterface

/* rtl/srcs_store.sv */
// Byte-wide register store with a clearing sweep after reset.
`timescale 1ns / 1ps
module srcs_store #(
	parameter int ADDR_BITS = srcs_pkg::STORE_ADDR_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srcs_pkg::store_req_t   req,
	output logic [7:0]             rdata,
	output logic                   busy
);
	import srcs_pkg::*;

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [7:0]           mem [DEPTH];
	logic                 clr_q;
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic [7:0]           rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
			if (&clr_addr_q) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (req.wr) begin
			mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[req.addr[ADDR_BITS-1:0]];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_q;

`ifndef SYNTHESIS
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !req.rd && !req.wr)
		else $error("store access during clearing sweep");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd && req.wr))
		else $error("read and write requested together");
	a_sweep_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> clr_addr_q == '0)
		else $error("clearing sweep ended early");
`endif

endmodule

/* rtl/spi_register_command_slave.sv */
// Top level: SPI byte-slot command sequencer over the register store.
//
//  channel | dir | payload                          | accepted when
//  rx      | in  | rx_byte                          | rx.valid && rx.ready
//  tx      | out | tx_byte, phase, transfer_done    | tx.valid && tx.ready
//
// One request per cycle while rx.ready is high; its result appears in the cycle
// after acceptance. The output register frees when tx takes it, so
// rx.ready = !store_busy && (!tx.valid || tx.ready). Read slots fetch one store
// byte through the registered read port. After reset a clearing sweep zeroes
// the store with rx.ready held low.
`timescale 1ns / 1ps
module spi_register_command_slave #(
	parameter int STORE_ADDR_BITS = srcs_pkg::STORE_ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srcs_rx_if.sink    rx,
	srcs_tx_if.source  tx
);
	import srcs_pkg::*;

	typedef enum logic [2:0] {
		ST_HDR = 3'b001,
		ST_RD  = 3'b010,
		ST_WR  = 3'b100
	} state_t;

	state_t      state_q, state_d;
	logic [23:0] hdr_q, hdr_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] addr_q, addr_d;
	logic [6:0]  words_q, words_d;
	logic [1:0]  biw_q, biw_d;
	logic        inc_q, inc_d;

	logic        valid_s1;
	logic [1:0]  ph_s1;
	logic        done_s1;
	logic        rd_s1;

	logic [1:0]  ph_d;
	logic        done_d;
	logic        rd_d;

	logic        accept;
	logic        in_ready;
	logic        store_busy;
	logic [7:0]  store_rdata;
	store_req_t  req;

	logic [1:0]  biw_inc;
	logic [15:0] addr_next_word;
	logic [6:0]  words_dec;
	logic        last_word;
	logic [6:0]  hdr_count;
	logic [3:0]  hdr_cmd;

	assign in_ready = !store_busy && (!valid_s1 || tx.ready);
	assign rx.ready = in_ready;
	assign accept   = rx.valid && in_ready;

	assign biw_inc        = biw_q + 2'd1;
	assign addr_next_word = inc_q ? addr_q + 16'd4 : addr_q;
	assign words_dec      = words_q - 7'd1;
	assign last_word      = (words_q == 7'd1);
	assign hdr_count      = {hdr_q[2:0], rx.rx_byte[7:4]};
	assign hdr_cmd        = hdr_q[7:4];

	always_comb begin
		state_d   = state_q;
		hdr_d     = hdr_q;
		hcnt_d    = hcnt_q;
		addr_d    = addr_q;
		words_d   = words_q;
		biw_d     = biw_q;
		inc_d     = inc_q;
		ph_d      = PH_HDR;
		done_d    = 1'b0;
		rd_d      = 1'b0;
		req.rd    = 1'b0;
		req.wr    = 1'b0;
		req.addr  = addr_q;
		req.wdata = rx.rx_byte;
		case (state_q)
			ST_RD: begin
				ph_d     = PH_RD;
				rd_d     = 1'b1;
				req.rd   = accept;
				req.addr = addr_q + {14'd0, biw_q};
			end
			ST_WR: begin
				ph_d     = PH_WR;
				req.wr   = accept;
				req.addr = {addr_q[15:2], biw_q};
			end
			ST_HDR: begin
				if (hcnt_q != HDR_LAST) begin
					hdr_d  = {hdr_q[15:0], rx.rx_byte};
					hcnt_d = hcnt_q + 2'd1;
				end else begin
					hdr_d   = '0;
					hcnt_d  = '0;
					addr_d  = hdr_q[23:8];
					inc_d   = hdr_q[3];
					words_d = hdr_count;
					biw_d   = '0;
					if (hdr_count != 7'd0 && hdr_cmd == CMD_RD) begin
						state_d = ST_RD;
					end else if (hdr_count != 7'd0 && hdr_cmd == CMD_WR) begin
						state_d = ST_WR;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_HDR;
			end
		endcase
		// advance within the word; close the word after its last byte
		if (state_q == ST_RD || state_q == ST_WR) begin
			biw_d = biw_inc;
			if (&biw_q) begin
				addr_d  = addr_next_word;
				words_d = words_dec;
				if (last_word) begin
					state_d = ST_HDR;
					done_d  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HDR;
			hdr_q   <= '0;
			hcnt_q  <= '0;
			addr_q  <= '0;
			words_q <= '0;
			biw_q   <= '0;
			inc_q   <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			hdr_q   <= hdr_d;
			hcnt_q  <= hcnt_d;
			addr_q  <= addr_d;
			words_q <= words_d;
			biw_q   <= biw_d;
			inc_q   <= inc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (tx.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			ph_s1   <= ph_d;
			done_s1 <= done_d;
			rd_s1   <= rd_d;
		end
	end

	srcs_store #(
		.ADDR_BITS (STORE_ADDR_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (store_rdata),
		.busy   (store_busy)
	);

	assign tx.valid         = valid_s1;
	assign tx.tx_byte       = rd_s1 ? store_rdata : FILLER;
	assign tx.phase         = ph_s1;
	assign tx.transfer_done = done_s1;

`ifndef SYNTHESIS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> !rx.ready)
		else $error("request accepted during store clearing");
	a_hdr_count_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q != 2'd0 |-> state_q == ST_HDR)
		else $error("header count nonzero outside header phase");
	a_words_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> words_q != 7'd0)
		else $error("data phase with no words left");
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> tx.valid)
		else $error("accepted request produced no result");
`endif

endmodule
